@@ rtl/sorted_list_merge_core_macros.svh @@
// Assertion macros for the sorted list merge core.
`ifndef SORTED_LIST_MERGE_CORE_MACROS_SVH
`define SORTED_LIST_MERGE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SLM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted_list_merge_core: assertion failed");
`else
`define SLM_ASSERT_SAME(label, clk, rst, ante, cons)
`endif

`ifndef NO_ASSERTIONS
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_list_merge_core: assertion failed");
`else
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/slm_pkg.sv @@
`timescale 1ns / 1ps

package slm_pkg;

   localparam int ListDepthDefault = 32;
   localparam int ValueWidth       = 32;

   localparam logic [1:0] ACTION_PUSH_FIRST  = 2'd0;
   localparam logic [1:0] ACTION_PUSH_SECOND = 2'd1;
   localparam logic [1:0] ACTION_RUN         = 2'd2;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] merged_value;
      logic                         is_last;
      logic                         dropped;
   } rsp_type;

endpackage

@@ rtl/sorted_list_merge_core.sv @@
`timescale 1ns / 1ps
// Push: one request per idle cycle, no result, RAM written in that cycle.
// Run: first merged value passes the buffer read and response registers,
// then one value per cycle from the two buffer read ports while rsp_ready
// is high; a run holds off requests until its last value is registered.
// Synchronous reset empties both lists and clears the drop flag; buffer
// contents are not cleared and are never used before being written.
`include "sorted_list_merge_core_macros.svh"

module sorted_list_merge_core #(
   parameter int LIST_DEPTH = slm_pkg::ListDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slm_pkg::rsp_type rsp_payload
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [CW-1:0]    idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic             overflow_ff, overflow_in;
   logic             run_drop_ff, run_drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   slm_pkg::rsp_type rsp_ff, rsp_in;

   logic                            req_fire, push1, push2, run_req;
   logic                            wr1_en, wr2_en, advance, take1, last;
   logic signed [slm_pkg::ValueWidth-1:0] head1, head2;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign push1     = req_fire && (req_payload.action == slm_pkg::ACTION_PUSH_FIRST);
   assign push2     = req_fire && (req_payload.action == slm_pkg::ACTION_PUSH_SECOND);
   assign run_req   = req_fire && (req_payload.action == slm_pkg::ACTION_RUN);
   assign wr1_en    = push1 && (cnt1_ff < CW'(LIST_DEPTH));
   assign wr2_en    = push2 && (cnt2_ff < CW'(LIST_DEPTH));

   slm_ram #(
      .WIDTH      (slm_pkg::ValueWidth),
      .DEPTH      (LIST_DEPTH),
      .ADDR_WIDTH (AW)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (cnt1_ff[AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (idx1_in[AW-1:0]),
      .rd_data (head1)
   );

   slm_ram #(
      .WIDTH      (slm_pkg::ValueWidth),
      .DEPTH      (LIST_DEPTH),
      .ADDR_WIDTH (AW)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (wr2_en),
      .wr_addr (cnt2_ff[AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (idx2_in[AW-1:0]),
      .rd_data (head2)
   );

   // first list goes out only on a strictly smaller head or an exhausted second list
   assign take1 = (idx1_ff < cnt1_ff) && ((idx2_ff >= cnt2_ff) || (head1 < head2));
   assign last  = take1 ? (((idx1_ff + CW'(1)) == cnt1_ff) && (idx2_ff == cnt2_ff))
                        : (((idx2_ff + CW'(1)) == cnt2_ff) && (idx1_ff == cnt1_ff));
   assign advance = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt1_in      = cnt1_ff;
      cnt2_in      = cnt2_ff;
      idx1_in      = idx1_ff;
      idx2_in      = idx2_ff;
      overflow_in  = overflow_ff;
      run_drop_in  = run_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push1) begin
               if (wr1_en) begin
                  cnt1_in = cnt1_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            if (push2) begin
               if (wr2_en) begin
                  cnt2_in = cnt2_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            if (run_req) begin
               run_drop_in = overflow_ff;
               overflow_in = 1'b0;
               if ((cnt1_ff != '0) || (cnt2_ff != '0)) begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            if (advance) begin
               rsp_valid_in        = 1'b1;
               rsp_in.merged_value = take1 ? head1 : head2;
               rsp_in.is_last      = last;
               rsp_in.dropped      = run_drop_ff;
               if (take1) begin
                  idx1_in = idx1_ff + CW'(1);
               end else begin
                  idx2_in = idx2_ff + CW'(1);
               end
               if (last) begin
                  state_in = ST_IDLE;
                  idx1_in  = '0;
                  idx2_in  = '0;
                  cnt1_in  = '0;
                  cnt2_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         idx1_ff      <= '0;
         idx2_ff      <= '0;
         overflow_ff  <= 1'b0;
         run_drop_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         idx1_ff      <= idx1_in;
         idx2_ff      <= idx2_in;
         overflow_ff  <= overflow_in;
         run_drop_ff  <= run_drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SLM_ASSERT_SAME(a_idx_in_range, clock, reset, 1'b1,
      (idx1_ff <= cnt1_ff) && (idx2_ff <= cnt2_ff))
   `SLM_ASSERT_SAME(a_merge_has_work, clock, reset, state_ff == ST_MERGE,
      (idx1_ff < cnt1_ff) || (idx2_ff < cnt2_ff))
   `SLM_ASSERT_NEXT(a_run_clears_flag, clock, reset, run_req, !overflow_ff)
   `SLM_ASSERT_NEXT(a_last_empties, clock, reset, advance && last,
      (cnt1_ff == '0) && (cnt2_ff == '0) && (state_ff == ST_IDLE))

endmodule

@@ rtl/slm_ram.sv @@
`timescale 1ns / 1ps

module slm_ram #(
   parameter int WIDTH      = slm_pkg::ValueWidth,
   parameter int DEPTH      = slm_pkg::ListDepthDefault,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
